FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define BGAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, off while reset is low.
`define BGAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

// Next-cycle implication that also holds through reset.
`define BGAE_ASSERT_NXT_RAW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/bgae_pkg.sv
`default_nettype none
package bgae_pkg;

  localparam int CONTENT_W       = 32;
  localparam int ERR_W           = 31;
  localparam int CNT_W           = 7;
  localparam int IDX_W           = 8;
  localparam int SQ_W            = 64;
  localparam int ROOT_W          = 32;
  localparam int MAX_GROUP_DEF   = 64;
  localparam logic [CNT_W-1:0] RESET_GROUP_SIZE = 7'd20;
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  typedef struct packed {
    logic signed [CONTENT_W-1:0] bin_content;
    logic [ERR_W-1:0]            bin_error;
  } in_item_t;

  typedef struct packed {
    logic signed [CONTENT_W-1:0] mean_content;
    logic [ERR_W-1:0]            mean_error;
    logic [CNT_W-1:0]            used_count;
    logic [IDX_W-1:0]            group_index;
    logic                        squares_saturated;
  } out_item_t;

  // Closed group handed from front to back (content sum travels beside it).
  typedef struct packed {
    logic [SQ_W-1:0]  sq_sum;
    logic [CNT_W-1:0] used;
    logic [IDX_W-1:0] idx;
    logic             sat;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQRT,
    BK_DIVM,
    BK_DIVE,
    BK_OUT
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/bgae_front.sv
`default_nettype none
module bgae_front import bgae_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF,
  parameter int SUM_W     = CONTENT_W + $clog2(MAX_GROUP)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_item_t                in_data,
  input  wire logic [CNT_W-1:0]        cfg_size,
  input  wire logic                    q_full,
  output logic                         q_push,
  output job_t                         q_job,
  output logic signed [SUM_W-1:0]      q_sum
);

  // Stage A: registered item and squared error
  logic                        a_valid_r, a_valid_nxt;
  logic signed [CONTENT_W-1:0] a_content_r;
  logic                        a_nz_r;
  logic [2*ERR_W-1:0]          a_sq_r;

  // Stage B: group accumulators
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sqs_r, sqs_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic                    sat_r, sat_nxt;

  logic [CNT_W-1:0] eff_size;
  logic [SQ_W:0]    sq_add;
  logic             close;
  logic             a_take;
  logic             accept;

  // Clamp the configured size into range
  always_comb begin
    eff_size = cfg_size;
    if (cfg_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (int'(cfg_size) > MAX_GROUP) begin
      eff_size = CNT_W'(MAX_GROUP);
    end
  end

  // Accumulate the item in stage A
  always_comb begin
    sq_add  = {1'b0, sqs_r} + (SQ_W+1)'(a_sq_r);
    sum_nxt = sum_r;
    sqs_nxt = sqs_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    if (a_nz_r) begin
      sum_nxt = sum_r + SUM_W'(a_content_r);
      cnt_nxt = cnt_r + CNT_W'(1);
      if (sq_add[SQ_W]) begin
        sqs_nxt = {SQ_W{1'b1}};
        sat_nxt = 1'b1;
      end else begin
        sqs_nxt = sq_add[SQ_W-1:0];
      end
    end
    pos_nxt = pos_r + CNT_W'(1);
  end

  assign close    = (pos_nxt >= eff_size);
  assign a_take   = a_valid_r && !(close && q_full);
  assign in_stall = a_valid_r && !a_take;
  assign accept   = in_valid && !in_stall;
  assign q_push   = a_take && close;

  assign q_sum      = sum_nxt;
  assign q_job.sq_sum = sqs_nxt;
  assign q_job.used = cnt_nxt;
  assign q_job.idx  = idx_r;
  assign q_job.sat  = sat_nxt;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  // Load stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    if (accept) begin
      a_content_r <= in_data.bin_content;
      a_nz_r      <= (in_data.bin_content != '0);
      a_sq_r      <= in_data.bin_error * in_data.bin_error;
    end
  end

  // Advance the group, clear on close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sqs_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      idx_r <= '0;
      sat_r <= 1'b0;
    end else if (a_take) begin
      if (close) begin
        sum_r <= '0;
        sqs_r <= '0;
        cnt_r <= '0;
        pos_r <= '0;
        sat_r <= 1'b0;
        idx_r <= idx_r + IDX_W'(1);
      end else begin
        sum_r <= sum_nxt;
        sqs_r <= sqs_nxt;
        cnt_r <= cnt_nxt;
        pos_r <= pos_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bgae_queue.sv
`default_nettype none
module bgae_queue import bgae_pkg::*; #(
  parameter int SUM_W = CONTENT_W + $clog2(MAX_GROUP_DEF)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire job_t                    push_job,
  input  wire logic signed [SUM_W-1:0] push_sum,
  output logic                         full,
  output logic                         q_valid,
  input  wire logic                    pop,
  output job_t                         pop_job,
  output logic signed [SUM_W-1:0]      pop_sum
);

  job_t                    job_r [2];
  logic signed [SUM_W-1:0] sum_r [2];
  logic                    wr_ptr_r, rd_ptr_r;
  logic [1:0]              count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign pop_job = job_r[rd_ptr_r];
  assign pop_sum = sum_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Move pointers and store the pushed group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (push) begin
      job_r[wr_ptr_r] <= push_job;
      sum_r[wr_ptr_r] <= push_sum;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bgae_div.sv
`default_nettype none
module bgae_div import bgae_pkg::*; #(
  parameter int DW = CONTENT_W + $clog2(MAX_GROUP_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  input  wire logic [DW-1:0] dividend,
  output logic               done,
  output logic [DW-1:0]      quot
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    quot_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] divisor_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quot_r[DW-1]};
    diff  = trial - {1'b0, divisor_r};
    ge    = (trial >= {1'b0, divisor_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= CW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
    if (req.start) begin
      quot_r    <= dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[DW-2:0], ge};
      rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

FILE: rtl/core/bgae_back.sv
`default_nettype none
module bgae_back import bgae_pkg::*; #(
  parameter int SUM_W = CONTENT_W + $clog2(MAX_GROUP_DEF)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  output logic                         q_pop,
  input  wire job_t                    q_job,
  input  wire logic signed [SUM_W-1:0] q_sum,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_item_t                    out_data
);

  back_state_t state_r, state_nxt;

  job_t                    job_r;
  logic [SUM_W-1:0]        abs_r;
  logic                    neg_r;
  logic [SQ_W-1:0]         v_r, r_r, bit_r;
  logic [SQ_W-1:0]         rb;
  logic [CONTENT_W-1:0]    mean_r;
  logic [ERR_W-1:0]        merr_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic                    sqrt_init, sqrt_last, out_load, sel_root;
  div_req_t                dreq;
  logic [SUM_W-1:0]        dividend;
  logic                    div_done;
  logic [SUM_W-1:0]        quot;

  bgae_div #(.DW(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .dividend (dividend),
    .done     (div_done),
    .quot     (quot)
  );

  assign sqrt_last = bit_r[0];
  assign rb        = r_r + bit_r;
  assign dividend  = sel_root ? {{(SUM_W-ROOT_W){1'b0}}, r_r[ROOT_W-1:0]} : abs_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_job.used == '0) ? BK_OUT : BK_SQRT;
        end
      end
      BK_SQRT: if (sqrt_last) state_nxt = BK_DIVM;
      BK_DIVM: if (div_done) state_nxt = BK_DIVE;
      BK_DIVE: if (div_done) state_nxt = BK_OUT;
      BK_OUT:  if (!out_valid_r || !out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop        = 1'b0;
    sqrt_init    = 1'b0;
    out_load     = 1'b0;
    sel_root     = 1'b0;
    dreq.start   = 1'b0;
    dreq.divisor = job_r.used;
    unique case (state_r)
      BK_IDLE: begin
        q_pop     = q_valid;
        sqrt_init = q_valid;
      end
      BK_SQRT: dreq.start = sqrt_last;
      BK_DIVM: begin
        sel_root   = 1'b1;
        dreq.start = div_done;
      end
      BK_DIVE: sel_root = 1'b1;
      BK_OUT:  out_load = !out_valid_r || !out_stall;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the group, step the root, collect quotients
  always_ff @(posedge clk) begin
    if (sqrt_init) begin
      job_r  <= q_job;
      neg_r  <= q_sum[SUM_W-1];
      abs_r  <= q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
      v_r    <= q_job.sq_sum;
      r_r    <= '0;
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
      mean_r <= '0;
      merr_r <= '0;
    end else if (state_r == BK_SQRT) begin
      if (v_r >= rb) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (state_r == BK_DIVM && div_done) begin
      mean_r <= neg_r ? (-quot[CONTENT_W-1:0]) : quot[CONTENT_W-1:0];
    end
    if (state_r == BK_DIVE && div_done) begin
      merr_r <= (quot[SUM_W-1:ERR_W] != '0) ? ERR_MAX : quot[ERR_W-1:0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_r.mean_content      <= mean_r;
      out_r.mean_error        <= merr_r;
      out_r.used_count        <= job_r.used;
      out_r.group_index       <= job_r.idx;
      out_r.squares_saturated <= (job_r.used != '0) && job_r.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/bin_group_average_with_error.sv
// Rebins a stream of Q16.16 histogram bins: every group_size input items give one result
// item with the mean of the non-zero contents and sqrt(sum of squared errors) divided by
// the used count. The front end accepts one item per cycle unless a group closes while
// the two-entry queue it closes groups into is full; the back end runs a 32-step square
// root and two shift-subtract divisions on one shared divider per non-empty group. When
// groups arrive faster than the back end finishes them, in_stall paces the input.
// group_size is to be written through the cfg port (always ready) only while the block
// is idle; the block itself does not enforce this. 0 acts as 1, values above MAX_GROUP
// act as MAX_GROUP, reset value 20.
`default_nettype none
module bin_group_average_with_error import bgae_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int SUM_W = CONTENT_W + $clog2(MAX_GROUP);

  logic [CNT_W-1:0]        group_size_r;
  logic                    q_full, q_push, q_valid, q_pop;
  job_t                    push_job, pop_job;
  logic signed [SUM_W-1:0] push_sum, pop_sum;

  assign cfg_ready = 1'b1;

  // Hold the group size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= RESET_GROUP_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      group_size_r <= cfg_data;
    end
  end

  bgae_front #(.MAX_GROUP(MAX_GROUP), .SUM_W(SUM_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_size (group_size_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job),
    .q_sum    (push_sum)
  );

  bgae_queue #(.SUM_W(SUM_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .push_sum (push_sum),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .pop_sum  (pop_sum)
  );

  bgae_back #(.SUM_W(SUM_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (pop_job),
    .q_sum     (pop_sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bgae_checker.sv
`default_nettype none
`include "assert_macros.svh"
module bgae_assertions import bgae_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  logic empty_zero;

  assign empty_zero = (out_data.mean_content == '0) && (out_data.mean_error == '0) &&
                      !out_data.squares_saturated;

  // No result comes straight out of reset
  `BGAE_ASSERT_NXT_RAW(a_reset_quiet, clk, !rst_n, !out_valid)

  // A stalled result stays
  `BGAE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // An empty group reports all zero
  `BGAE_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && (out_data.used_count == '0), empty_zero)

  // A group never holds more bins than MAX_GROUP_DEF allows
  `BGAE_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, out_data.used_count <= CNT_W'(MAX_GROUP_DEF))

endmodule

bind bin_group_average_with_error bgae_assertions u_chk (.*);
`default_nettype wire
